// File: sv/bst_pkg.sv
// Shared types, constants and command codes of the beat scheduler.
`timescale 1ns / 1ps
package bst_pkg;

  localparam int unsigned SAMPLE_RATE       = 48000;
  localparam int unsigned TAP_SLOTS         = 8;
  localparam int unsigned TAP_AGE_US        = 3000000;
  localparam int unsigned TAP_WINDOW_FRAMES = 9600;
  localparam int unsigned MAX_BEATS         = 16;

  localparam int unsigned FRAME_W = 48;
  localparam int unsigned TEMPO_W = 18;
  localparam int unsigned TIME_W  = 40;
  localparam int unsigned DIV_W   = 40;
  localparam int unsigned PTR_W   = (TAP_SLOTS > 1) ? $clog2(TAP_SLOTS) : 1;
  localparam int unsigned CNT_W   = $clog2(TAP_SLOTS + 1);

  localparam logic [TEMPO_W-1:0] TEMPO_MAX   = '1;
  localparam logic [TEMPO_W-1:0] TEMPO_RESET = TEMPO_W'(30720);
  localparam logic [DIV_W-1:0] INTV_NUM = DIV_W'(64'(SAMPLE_RATE) * 64'd240 * 64'd256);
  localparam logic [DIV_W-1:0] TAP_NUM  = DIV_W'(64'd60000000 * 64'd256);
  localparam logic [31:0] INTV_MAX = '1;

  localparam logic [1:0] CMD_PERIOD = 2'd0;
  localparam logic [1:0] CMD_TAP    = 2'd1;
  localparam logic [1:0] CMD_START  = 2'd2;
  localparam logic [1:0] CMD_STOP   = 2'd3;

  localparam logic [2:0] CFG_BASE_TEMPO   = 3'd0;
  localparam logic [2:0] CFG_TEMPO_STEP   = 3'd1;
  localparam logic [2:0] CFG_RAMP_START   = 3'd2;
  localparam logic [2:0] CFG_RAMP_LIMIT   = 3'd3;
  localparam logic [2:0] CFG_BEATS_PER_BAR = 3'd4;
  localparam logic [2:0] CFG_NOTE_VALUE   = 3'd5;
  localparam logic [2:0] CFG_ACCENT       = 3'd6;
  localparam logic [2:0] CFG_PATTERN_EN   = 3'd7;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [12:0]       period_frames;
    logic [TIME_W-1:0] tap_time_us;
  } in_t;

  typedef struct packed {
    logic               click;
    logic               emphasis;
    logic [11:0]        click_offset;
    logic [3:0]         beat_number;
    logic [TEMPO_W-1:0] tempo_now;
    logic               running;
  } out_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_REALIGN,
    OP_EVAL,
    OP_DIV_TRAIN,
    OP_TRAIN_APPLY,
    OP_DIV_INTV,
    OP_INTV_APPLY,
    OP_ADVANCE,
    OP_START,
    OP_STOP,
    OP_TAP_RDNEW,
    OP_TAP_REV,
    OP_TAP_INS,
    OP_TAP_AGE,
    OP_DIV_TAP,
    OP_TAP_APPLY,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       hit;
    logic       train_en;
    logic       div_done;
    logic       tap_aged;
    logic       tap_multi;
  } stat_t;

endpackage

// File: sv/beat_scheduler_tap_tempo.sv
// Top level of the metronome beat scheduler with speed trainer and tap tempo.
`timescale 1ns / 1ps
// One request is processed at a time. A stop, a start or an audio period without a
// beat needs no divider pass; a period with a beat runs one pass of the shared serial
// divider, or two when the speed trainer steps. A tap removes each stored tap that
// ages out from the tap history and runs one divider pass once two or more taps
// are stored.
// The next request is taken as soon as the result is in the output register.
module beat_scheduler_tap_tempo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bst_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bst_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);

  bst_pkg::ctrl_t ctrl;
  bst_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  bst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  bst_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: sv/bst_div.sv
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module bst_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bst_pkg::DIV_W-1:0] dividend_i,
  input  logic [bst_pkg::DIV_W-1:0] divisor_i,
  output logic [bst_pkg::DIV_W-1:0] quotient_o,
  output logic                      done_o
);

  localparam int unsigned W   = bst_pkg::DIV_W;
  localparam int unsigned CW  = $clog2(W + 1);

  logic [W-1:0]  rem_q, quo_q, den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [W:0]    trial;
  logic          ge;

  assign trial = {rem_q, quo_q[W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? W'(trial - {1'b0, den_q}) : trial[W-1:0];
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// File: sv/bst_dp.sv
// Datapath: configuration, beat and tap state, tap history memory, result register.
`timescale 1ns / 1ps
module bst_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bst_pkg::ctrl_t        ctrl_i,
  output bst_pkg::stat_t        stat_o,
  input  bst_pkg::in_t          in_data_i,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [31:0]           cfg_data_i,
  output bst_pkg::out_t         out_data_o
);

  localparam int unsigned FW = bst_pkg::FRAME_W;
  localparam int unsigned TW = bst_pkg::TEMPO_W;
  localparam int unsigned DW = bst_pkg::DIV_W;
  localparam int unsigned PW = bst_pkg::PTR_W;
  localparam int unsigned CW = bst_pkg::CNT_W;
  localparam int unsigned XW = bst_pkg::TIME_W;

  logic [TW-1:0]        rstart_q, rlimit_q;
  logic signed [15:0]   step_q;
  logic [4:0]           bpb_q;
  logic [6:0]           note_q;
  logic [31:0]          accent_q;
  logic                 pen_q;

  logic [FW-1:0]        frame_q, next_q, last_q;
  logic [3:0]           bidx_q;
  logic [TW-1:0]        cur_q, tapped_q;
  logic                 pend_q, active_q;
  logic [PW-1:0]        head_q;
  logic [CW-1:0]        cnt_q;

  logic [1:0]           cmd_q;
  logic [12:0]          n_q;
  logic [XW-1:0]        now_q;

  logic                 click_q, emph_q;
  logic [11:0]          offs_q;
  logic [3:0]           bnum_q;
  bst_pkg::out_t        out_q;

  logic [XW-1:0]        tap_mem [bst_pkg::TAP_SLOTS];
  logic [XW-1:0]        rd_q;
  logic [PW-1:0]        rd_addr, wr_addr, head_inc, newest;
  logic                 wr_en;

  logic [4:0]           beats, bdiv;
  logic [FW:0]          frame_end;
  logic                 hit, train_en;
  logic [FW-1:0]        gap, beat_age;
  logic [11:0]          offs;
  logic [1:0]           code;
  logic [15:0]          step_mag;
  logic [19:0]          tsum;
  logic [TW-1:0]        tsat, tclamp, bound;
  logic [24:0]          den;
  logic [31:0]          intv;
  logic [3:0]           bnext;
  logic [CW:0]          wsum, nsum;
  logic                 aged, tap_full;
  logic [CW-1:0]        cnt_m1;
  logic [TW-1:0]        ttempo;

  logic                 div_start, div_done;
  logic [DW-1:0]        div_a, div_b, div_q;

  bst_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .quotient_o (div_q),
    .done_o     (div_done)
  );

  always_comb begin
    beats = (bpb_q > 5'(bst_pkg::MAX_BEATS)) ? 5'(bst_pkg::MAX_BEATS) : bpb_q;
    bdiv  = (beats == 5'd0) ? 5'd1 : beats;

    frame_end = {1'b0, frame_q} + {{(FW - 12){1'b0}}, n_q};
    hit       = active_q && (frame_end > {1'b0, next_q});
    train_en  = (frame_q != '0) && (step_q != '0);
    gap       = next_q - frame_q;
    offs      = (next_q > frame_q) ? ((gap > FW'(4095)) ? 12'd4095 : gap[11:0]) : 12'd0;
    code      = accent_q[{bidx_q, 1'b0} +: 2];
    beat_age  = frame_q - last_q;

    step_mag = step_q[15] ? 16'(-step_q) : 16'(step_q);
    tsum     = step_q[15] ? 20'({2'b00, cur_q} - {4'b0000, div_q[15:0]})
                          : 20'({2'b00, cur_q} + {4'b0000, div_q[15:0]});
    if (tsum[19]) tsat = '0;
    else if (tsum > {2'b00, bst_pkg::TEMPO_MAX}) tsat = bst_pkg::TEMPO_MAX;
    else tsat = tsum[TW-1:0];
    bound  = (rlimit_q != '0) ? rlimit_q : tapped_q;
    tclamp = tsat;
    if (rlimit_q != '0 || rstart_q != '0) begin
      if (!step_q[15]) tclamp = (tsat > bound) ? bound : tsat;
      else             tclamp = (tsat < bound) ? bound : tsat;
    end

    den   = cur_q * note_q;
    intv  = (div_q > {{(DW - 32){1'b0}}, bst_pkg::INTV_MAX}) ? bst_pkg::INTV_MAX : div_q[31:0];
    bnext = bidx_q + 4'd1;

    head_inc = (head_q == PW'(bst_pkg::TAP_SLOTS - 1)) ? '0 : PW'(head_q + 1'b1);
    nsum = {1'b0, CW'(head_q)} + {1'b0, cnt_q} - (CW+1)'(1);
    if (nsum >= (CW+1)'(bst_pkg::TAP_SLOTS)) nsum = nsum - (CW+1)'(bst_pkg::TAP_SLOTS);
    newest = nsum[PW-1:0];
    wsum = {1'b0, CW'(head_q)} + {1'b0, cnt_q};
    if (wsum >= (CW+1)'(bst_pkg::TAP_SLOTS)) wsum = wsum - (CW+1)'(bst_pkg::TAP_SLOTS);
    tap_full = cnt_q == CW'(bst_pkg::TAP_SLOTS);
    wr_addr  = tap_full ? head_q : wsum[PW-1:0];
    wr_en    = ctrl_i.op == bst_pkg::OP_TAP_INS;
    rd_addr  = (ctrl_i.op == bst_pkg::OP_TAP_RDNEW) ? newest : head_q;
    aged     = ({1'b0, rd_q} + (XW+1)'(bst_pkg::TAP_AGE_US)) < {1'b0, now_q};
    cnt_m1   = cnt_q - CW'(1);
    ttempo   = (div_q > {{(DW - TW){1'b0}}, bst_pkg::TEMPO_MAX}) ? bst_pkg::TEMPO_MAX
                                                                : div_q[TW-1:0];

    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    case (ctrl_i.op)
      bst_pkg::OP_DIV_TRAIN: begin
        div_start = 1'b1;
        div_a     = {{(DW - 16){1'b0}}, step_mag};
        div_b     = {{(DW - 5){1'b0}}, bdiv};
      end
      bst_pkg::OP_DIV_INTV: begin
        div_start = 1'b1;
        div_a     = bst_pkg::INTV_NUM;
        div_b     = {{(DW - 25){1'b0}}, den};
      end
      bst_pkg::OP_DIV_TAP: begin
        div_start = 1'b1;
        div_a     = DW'(bst_pkg::TAP_NUM * {{(DW - CW){1'b0}}, cnt_m1});
        div_b     = now_q - rd_q;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) tap_mem[wr_addr] <= now_q;
    rd_q <= tap_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= '0;
      rstart_q <= '0;
      rlimit_q <= '0;
      bpb_q    <= 5'd4;
      note_q   <= 7'd4;
      accent_q <= '0;
      pen_q    <= 1'b0;
      frame_q  <= '0;
      next_q   <= '0;
      last_q   <= '0;
      bidx_q   <= '0;
      cur_q    <= '0;
      tapped_q <= bst_pkg::TEMPO_RESET;
      pend_q   <= 1'b0;
      active_q <= 1'b0;
      head_q   <= '0;
      cnt_q    <= '0;
    end else begin
      case (ctrl_i.op)
        bst_pkg::OP_REALIGN: begin
          if (pend_q) begin
            next_q <= (beat_age < FW'(bst_pkg::TAP_WINDOW_FRAMES)) ? FW'(next_q + beat_age)
                                                                   : frame_q;
            pend_q <= 1'b0;
          end
        end
        bst_pkg::OP_TRAIN_APPLY: cur_q <= tclamp;
        bst_pkg::OP_INTV_APPLY: begin
          last_q <= next_q;
          next_q <= next_q + {{(FW - 32){1'b0}}, intv};
          bidx_q <= ({1'b0, bnext} >= beats) ? 4'd0 : bnext;
        end
        bst_pkg::OP_ADVANCE: begin
          if (active_q) frame_q <= frame_end[FW-1:0];
        end
        bst_pkg::OP_START: begin
          bidx_q   <= '0;
          next_q   <= '0;
          frame_q  <= '0;
          cur_q    <= (step_q != '0 && rstart_q != '0) ? rstart_q : tapped_q;
          active_q <= 1'b1;
        end
        bst_pkg::OP_STOP: begin
          cur_q    <= '0;
          active_q <= 1'b0;
        end
        bst_pkg::OP_TAP_REV: begin
          if (cnt_q != '0 && now_q < rd_q) begin
            cnt_q <= '0;
            head_q <= '0;
          end
        end
        bst_pkg::OP_TAP_INS: begin
          if (tap_full) head_q <= head_inc;
          else cnt_q <= cnt_q + 1'b1;
        end
        bst_pkg::OP_TAP_AGE: begin
          if (aged) begin
            head_q <= head_inc;
            cnt_q  <= cnt_q - 1'b1;
          end
        end
        bst_pkg::OP_TAP_APPLY: begin
          tapped_q <= ttempo;
          if (active_q) begin
            cur_q  <= ttempo;
            pend_q <= 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (cfg_we_i) begin
        case (cfg_index_i)
          bst_pkg::CFG_BASE_TEMPO: begin
            tapped_q <= cfg_data_i[TW-1:0];
            if (active_q) cur_q <= cfg_data_i[TW-1:0];
          end
          bst_pkg::CFG_TEMPO_STEP:    step_q   <= $signed(cfg_data_i[15:0]);
          bst_pkg::CFG_RAMP_START:    rstart_q <= cfg_data_i[TW-1:0];
          bst_pkg::CFG_RAMP_LIMIT:    rlimit_q <= cfg_data_i[TW-1:0];
          bst_pkg::CFG_BEATS_PER_BAR: bpb_q    <= cfg_data_i[4:0];
          bst_pkg::CFG_NOTE_VALUE:    note_q   <= cfg_data_i[6:0];
          bst_pkg::CFG_ACCENT:        accent_q <= cfg_data_i;
          bst_pkg::CFG_PATTERN_EN:    pen_q    <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      bst_pkg::OP_LATCH: begin
        cmd_q   <= in_data_i.cmd;
        n_q     <= in_data_i.period_frames;
        now_q   <= in_data_i.tap_time_us;
        click_q <= 1'b0;
        emph_q  <= 1'b0;
        offs_q  <= '0;
        bnum_q  <= '0;
      end
      bst_pkg::OP_EVAL: begin
        if (hit) begin
          if (pen_q) begin
            click_q <= code != 2'd0;
            emph_q  <= code == 2'd2;
            offs_q  <= (code != 2'd0) ? offs : 12'd0;
            bnum_q  <= (code != 2'd0) ? bidx_q : 4'd0;
          end else begin
            click_q <= 1'b1;
            emph_q  <= (bidx_q == 4'd0) && (beats != 5'd0);
            offs_q  <= offs;
            bnum_q  <= bidx_q;
          end
        end
      end
      bst_pkg::OP_OUT: begin
        out_q.click        <= click_q;
        out_q.emphasis     <= emph_q;
        out_q.click_offset <= offs_q;
        out_q.beat_number  <= bnum_q;
        out_q.tempo_now    <= cur_q;
        out_q.running      <= active_q;
      end
      default: begin
      end
    endcase
  end

  assign stat_o.cmd       = cmd_q;
  assign stat_o.hit       = hit;
  assign stat_o.train_en  = train_en;
  assign stat_o.div_done  = div_done;
  assign stat_o.tap_aged  = aged;
  assign stat_o.tap_multi = cnt_q > CW'(1);
  assign out_data_o       = out_q;

endmodule

// File: sv/bst_ctrl.sv
// Controller: sequences one request through the datapath and owns the handshakes.
`timescale 1ns / 1ps
module bst_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  bst_pkg::stat_t stat_i,
  output bst_pkg::ctrl_t ctrl_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_EVAL, S_TSTART, S_TWAIT, S_ISTART, S_IWAIT, S_ADV,
    S_TREV, S_TINS, S_TRD, S_TAGE, S_KSTART, S_KWAIT, S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  bst_pkg::op_e op;

  always_comb begin
    state_d     = state_q;
    op          = bst_pkg::OP_NONE;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op      = bst_pkg::OP_LATCH;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat_i.cmd)
          bst_pkg::CMD_PERIOD: begin
            op = bst_pkg::OP_REALIGN;
            state_d = S_EVAL;
          end
          bst_pkg::CMD_TAP: begin
            op = bst_pkg::OP_TAP_RDNEW;
            state_d = S_TREV;
          end
          bst_pkg::CMD_START: begin
            op = bst_pkg::OP_START;
            state_d = S_OUT;
          end
          default: begin
            op = bst_pkg::OP_STOP;
            state_d = S_OUT;
          end
        endcase
      end
      S_EVAL: begin
        op = bst_pkg::OP_EVAL;
        if (!stat_i.hit) state_d = S_ADV;
        else if (stat_i.train_en) state_d = S_TSTART;
        else state_d = S_ISTART;
      end
      S_TSTART: begin
        op = bst_pkg::OP_DIV_TRAIN;
        state_d = S_TWAIT;
      end
      S_TWAIT: begin
        if (stat_i.div_done) begin
          op = bst_pkg::OP_TRAIN_APPLY;
          state_d = S_ISTART;
        end
      end
      S_ISTART: begin
        op = bst_pkg::OP_DIV_INTV;
        state_d = S_IWAIT;
      end
      S_IWAIT: begin
        if (stat_i.div_done) begin
          op = bst_pkg::OP_INTV_APPLY;
          state_d = S_ADV;
        end
      end
      S_ADV: begin
        op = bst_pkg::OP_ADVANCE;
        state_d = S_OUT;
      end
      S_TREV: begin
        op = bst_pkg::OP_TAP_REV;
        state_d = S_TINS;
      end
      S_TINS: begin
        op = bst_pkg::OP_TAP_INS;
        state_d = S_TRD;
      end
      S_TRD: begin
        state_d = S_TAGE;
      end
      S_TAGE: begin
        op = bst_pkg::OP_TAP_AGE;
        if (stat_i.tap_aged) state_d = S_TRD;
        else if (stat_i.tap_multi) state_d = S_KSTART;
        else state_d = S_OUT;
      end
      S_KSTART: begin
        op = bst_pkg::OP_DIV_TAP;
        state_d = S_KWAIT;
      end
      S_KWAIT: begin
        if (stat_i.div_done) begin
          op = bst_pkg::OP_TAP_APPLY;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          op          = bst_pkg::OP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign ctrl_o.op   = op;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted but controller stayed idle");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op == bst_pkg::OP_OUT |-> !out_valid_q || out_ready_i)
    else $error("result register overwritten before it was taken");

  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.div_done |-> state_q == S_TWAIT || state_q == S_IWAIT || state_q == S_KWAIT)
    else $error("divider finished outside a wait state");

endmodule
